// ===== hdl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// Key set table package
// Shared types, operation kinds, status codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int KEY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int OUT_W    = 24;  // status, position and count, padded to whole bytes

    // Operation kinds (the unused code acts as a search)
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/key_set_table_insert_delete_search.sv =====
// Operation: a search walks the live entries in S_SEARCH, then posts the result
//   from S_DONE; a delete that hits shifts the entries above the match down in S_SHIFT.
// Requests: taken one at a time, a new one only back in S_IDLE;
//   the key memory's one read port and its one equality compare set the walk rate.
// Reset: aresetn clears the entry count and control state; the key memory is
//   not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
// Key set table with insert, delete and search
// Packed table of distinct keys walked by one compare unit under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module key_set_table_insert_delete_search #(
    parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [kst_pkg::KEY_W-1:0]  s_axis_tdata,   // [31:0] key
    input  wire logic [kst_pkg::KIND_W-1:0] s_axis_tuser,   // [1:0] kind
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [kst_pkg::OUT_W-1:0]       m_axis_tdata    // [2:0] status, [10:3] position,
                                                            // [19:11] entry_count, [23:20] zero
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    kst_pkg::state_t state_reg, state_next;

    logic [kst_pkg::KEY_W-1:0]    mem [TABLE_DEPTH];
    logic [kst_pkg::KEY_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]             rd_addr;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [kst_pkg::KEY_W-1:0]    mem_wdata;

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             scan_reg, scan_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]             pend_idx_reg, pend_idx_next;
    logic [kst_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [kst_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [kst_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]             res_pos_reg, res_pos_next;
    logic                         m_valid_reg, m_valid_next;
    logic [kst_pkg::OUT_W-1:0]    m_data_reg, m_data_next;

    logic s_fire;
    logic search_hit;
    logic search_miss;
    logic shift_end;
    logic out_free;
    logic table_full;

    logic [kst_pkg::POS_W+IDX_W-1:0]   pos_wide;
    logic [kst_pkg::COUNT_W+CNT_W-1:0] cnt_wide;

    assign s_fire      = s_axis_tvalid && s_axis_tready;
    assign search_hit  = pend_valid_reg && (rd_data_reg == key_reg);
    assign search_miss = !pend_valid_reg && (scan_reg >= cnt_reg);
    assign shift_end   = !pend_valid_reg && (scan_reg >= cnt_reg);
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign table_full  = (cnt_reg == CNT_W'(TABLE_DEPTH));

    assign s_axis_tready = (state_reg == kst_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Key memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kst_pkg::S_IDLE: begin
                if (s_fire) begin
                    state_next = kst_pkg::S_SEARCH;
                end
            end
            kst_pkg::S_SEARCH: begin
                if (search_hit && kind_reg == kst_pkg::KIND_DELETE) begin
                    state_next = kst_pkg::S_SHIFT;
                end else if (search_hit || search_miss) begin
                    state_next = kst_pkg::S_DONE;
                end
            end
            kst_pkg::S_SHIFT: begin
                if (shift_end) begin
                    state_next = kst_pkg::S_DONE;
                end
            end
            kst_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = kst_pkg::S_IDLE;
                end
            end
            default: state_next = kst_pkg::S_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = pend_idx_reg - 1'b1;
        mem_wdata       = rd_data_reg;
        rd_addr         = scan_reg[IDX_W-1:0];
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        key_next        = key_reg;
        kind_next       = kind_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        pos_wide        = {{kst_pkg::POS_W{1'b0}}, res_pos_reg};
        cnt_wide        = {{kst_pkg::COUNT_W{1'b0}}, cnt_reg};

        unique case (state_reg)
            kst_pkg::S_IDLE: begin
                if (s_fire) begin
                    key_next  = s_axis_tdata;
                    kind_next = s_axis_tuser;
                    scan_next = '0;
                end
            end
            kst_pkg::S_SEARCH: begin
                if (search_hit || search_miss) begin
                    res_pos_next = search_hit ? pend_idx_reg : '0;
                    unique case (kind_reg)
                        kst_pkg::KIND_INSERT: begin
                            if (search_hit) begin
                                res_status_next = kst_pkg::ST_PRESENT;
                            end else if (table_full) begin
                                res_status_next = kst_pkg::ST_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                mem_waddr       = cnt_reg[IDX_W-1:0];
                                mem_wdata       = key_reg;
                                res_pos_next    = cnt_reg[IDX_W-1:0];
                                cnt_next        = cnt_reg + 1'b1;
                                res_status_next = kst_pkg::ST_INSERTED;
                            end
                        end
                        kst_pkg::KIND_DELETE: begin
                            if (search_hit) begin
                                // start the shift one past the matching entry
                                scan_next       = CNT_W'(pend_idx_reg) + 1'b1;
                                res_status_next = kst_pkg::ST_DELETED;
                            end else begin
                                res_status_next = kst_pkg::ST_MISSING;
                            end
                        end
                        default: begin
                            res_status_next = search_hit ? kst_pkg::ST_FOUND
                                                         : kst_pkg::ST_MISSING;
                        end
                    endcase
                end else if (scan_reg < cnt_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next       = scan_reg + 1'b1;
                end
            end
            kst_pkg::S_SHIFT: begin
                // read entry i+1 while writing the previous read down to i
                mem_we = pend_valid_reg;
                if (scan_reg < cnt_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next       = scan_reg + 1'b1;
                end else if (!pend_valid_reg) begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            kst_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, cnt_wide[kst_pkg::COUNT_W-1:0],
                                    pos_wide[kst_pkg::POS_W-1:0], res_status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kst_pkg::S_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        key_reg        <= key_next;
        kind_reg       <= kind_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_data_reg     <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/kst_checker.sv =====
// ----------------------------------------------------------------------------
// Key set table port checker
// Watches the stream ports of the key set table over time.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic [kst_pkg::KEY_W-1:0]  s_axis_tdata,
    input wire logic [kst_pkg::KIND_W-1:0] s_axis_tuser,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [kst_pkg::OUT_W-1:0]  m_axis_tdata
);

    logic unused_in;
    assign unused_in = ^{s_axis_tdata, s_axis_tuser};

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready high right after accepting a request");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= kst_pkg::ST_FOUND)
        else $error("status code out of range");

    // no position when the table is full or the key is missing
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[2:0] == kst_pkg::ST_FULL ||
                          m_axis_tdata[2:0] == kst_pkg::ST_MISSING)
        |-> m_axis_tdata[10:3] == 8'd0)
        else $error("nonzero position without a match");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind key_set_table_insert_delete_search kst_checker u_kst_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
